[rtl/sfb_pkg.sv]
// Shared types, constants and the sigmoid table builder for the sigmoid unit.
// No dependencies; every other file in rtl/ imports this package.
`timescale 1ns / 1ps

package sfb_pkg;

  localparam int NumStages       = 4;
  localparam int DefTablePoints  = 129;
  localparam int MaxTablePoints  = 1025;

  localparam logic OpForward  = 1'b0;
  localparam logic OpBackward = 1'b1;

  localparam logic [63:0] Q62One = 64'd1 << 62;

  typedef logic [15:0] rom_t [0:MaxTablePoints-1];

  // One load enable per pipeline stage, stage 0 first.
  typedef struct packed {
    logic [NumStages-1:0] en;
  } sfb_ctrl_t;

  // Restoring long division, one quotient bit per loop pass.
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Product of two Q2.62 values, kept in Q2.62.
  function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] prod;
    prod = {64'd0, a} * {64'd0, b};
    return prod[125:62];
  endfunction

  // Entry k holds round(65535 * sigmoid(8k / (points-1))), built with Q2.62 arithmetic.
  function automatic rom_t build_sig_rom(input int points);
    rom_t        rom;
    logic [63:0] segs;
    logic [63:0] step;
    logic [63:0] e;
    logic [63:0] term;
    logic [63:0] pw;
    logic [63:0] d;
    logic [63:0] q;
    for (int k = 0; k < MaxTablePoints; k++) begin
      rom[k] = '0;
    end
    segs = 64'(points - 1);
    step = udiv64(Q62One, segs) << 3;
    e    = Q62One;
    term = Q62One;
    pw   = Q62One;
    // exp(-step) from its alternating series.
    for (int n = 1; n <= 24; n++) begin
      term = udiv64(mul_q62(term, step), 64'(n));
      if (n % 2 == 1) begin
        e = e - term;
      end else begin
        e = e + term;
      end
    end
    for (int k = 0; k < points; k++) begin
      d      = (Q62One + pw) >> 20;
      q      = (udiv64(64'd65535 << 43, d) + 64'd1) >> 1;
      rom[k] = q[15:0];
      pw     = mul_q62(pw, e);
    end
    return rom;
  endfunction

endpackage

[rtl/sfb_pipe_ctrl.sv]
// Valid/ready control for the four-stage pipeline: per-stage valid bits and load enables.
// Depends on sfb_pkg.
`timescale 1ns / 1ps

module sfb_pipe_ctrl
  import sfb_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output sfb_ctrl_t ctrl_o
);

  logic [NumStages-1:0] valid_q;
  logic [NumStages-1:0] valid_d;
  logic [NumStages-1:0] stage_ready;
  logic [NumStages-1:0] valid_in;

  // A stage can load when it is empty or its word moves on in the same cycle.
  always_comb begin
    stage_ready[NumStages-1] = !valid_q[NumStages-1] || out_ready_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      stage_ready[k] = !valid_q[k] || stage_ready[k+1];
    end
    valid_in[0] = in_valid_i;
    for (int k = 1; k < NumStages; k++) begin
      valid_in[k] = valid_q[k-1];
    end
    for (int k = 0; k < NumStages; k++) begin
      ctrl_o.en[k] = valid_in[k] && stage_ready[k];
      valid_d[k]   = stage_ready[k] ? valid_in[k] : valid_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign in_ready_o  = stage_ready[0];
  assign out_valid_o = valid_q[NumStages-1];

`ifndef NO_ASSERTIONS
  for (genvar g = 0; g < NumStages - 1; g++) begin : g_hold_chk
    assert property (@(posedge clk_i) disable iff (!rst_ni)
      valid_q[g] && !stage_ready[g+1] |=> valid_q[g])
      else $error("stage %0d dropped a word while stalled", g);
  end

  for (genvar g = 0; g < NumStages; g++) begin : g_load_chk
    assert property (@(posedge clk_i) disable iff (!rst_ni)
      ctrl_o.en[g] |=> valid_q[g])
      else $error("stage %0d loaded but is not valid", g);
  end
`endif

endmodule

[rtl/sfb_fwd_path.sv]
// Forward datapath: |x| scaling, sigmoid table lookup, interpolation and sign fold.
// Depends on sfb_pkg (table builder, control struct).
`timescale 1ns / 1ps

module sfb_fwd_path
  import sfb_pkg::*;
#(
  parameter int TABLE_POINTS = DefTablePoints
) (
  input  logic         clk_i,
  input  sfb_ctrl_t    ctrl_i,
  input  logic signed [15:0] x_in_i,
  output logic [15:0]  y_o
);

  localparam int   SegW  = $clog2(TABLE_POINTS);
  localparam int   PosW  = 15 + SegW;
  localparam int   RomAw = $clog2(MaxTablePoints);
  localparam logic [SegW-1:0] Segs = SegW'(TABLE_POINTS - 1);
  localparam rom_t SigRom = build_sig_rom(TABLE_POINTS);

  // Stage 1: magnitude and table position.
  logic [15:0]     xr;
  logic [15:0]     mag;
  logic [PosW-1:0] pos;
  logic [SegW-1:0] idx_d;
  logic            sat_d;

  logic [SegW-1:0] idx_q;
  logic [14:0]     frac1_q;
  logic            neg1_q;
  logic            sat_q;

  assign xr    = x_in_i;
  assign mag   = xr[15] ? 16'(~xr + 16'd1) : xr;
  assign pos   = PosW'(mag) * PosW'(Segs);
  assign idx_d = pos[15 +: SegW];
  assign sat_d = idx_d >= Segs;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[0]) begin
      idx_q   <= idx_d;
      frac1_q <= pos[14:0];
      neg1_q  <= xr[15];
      sat_q   <= sat_d;
    end
  end

  // Stage 2: both neighboring table entries. At saturation both are the last entry.
  logic [SegW-1:0] idx_hi;
  logic [15:0]     lo2_q;
  logic [15:0]     hi2_q;
  logic [14:0]     frac2_q;
  logic            neg2_q;

  assign idx_hi = idx_q + SegW'(1);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[1]) begin
      lo2_q   <= sat_q ? SigRom[RomAw'(Segs)] : SigRom[RomAw'(idx_q)];
      hi2_q   <= sat_q ? SigRom[RomAw'(Segs)] : SigRom[RomAw'(idx_hi)];
      frac2_q <= frac1_q;
      neg2_q  <= neg1_q;
    end
  end

  // Stage 3: slope times fraction. The table rises, so the difference is never negative.
  logic [15:0] diff;
  logic [30:0] step3_q;
  logic [15:0] lo3_q;
  logic        neg3_q;

  assign diff = hi2_q - lo2_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[2]) begin
      step3_q <= 31'(diff) * 31'(frac2_q);
      lo3_q   <= lo2_q;
      neg3_q  <= neg2_q;
    end
  end

  // Stage 4: round, add, and mirror for negative inputs (65535 - y is ~y).
  logic [30:0] rnd;
  logic [15:0] y_pos;

  assign rnd   = step3_q + 31'h0000_4000;
  assign y_pos = lo3_q + rnd[30:15];

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[3]) begin
      y_o <= neg3_q ? ~y_pos : y_pos;
    end
  end

endmodule

[rtl/sfb_bwd_path.sv]
// Backward datapath: gradient dy * y * (1 - y), rounded to nearest with halves away from zero.
// Depends on sfb_pkg (control struct).
`timescale 1ns / 1ps

module sfb_bwd_path
  import sfb_pkg::*;
(
  input  logic               clk_i,
  input  sfb_ctrl_t          ctrl_i,
  input  logic [15:0]        sig_out_i,
  input  logic signed [15:0] grad_in_i,
  input  logic               propagate_i,
  output logic signed [16:0] grad_o,
  output logic               written_o
);

  // Stage 1: y * (1 - y) in Q0.32, at most 2^30, and |dy|.
  logic [15:0] dyr;
  logic [16:0] one_minus;
  logic [30:0] w_full;
  logic [30:0] w1_q;
  logic [15:0] mag1_q;
  logic        neg1_q;
  logic        prop1_q;

  assign dyr       = grad_in_i;
  assign one_minus = 17'h1_0000 - 17'(sig_out_i);
  assign w_full    = 31'(sig_out_i) * 31'(one_minus);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[0]) begin
      w1_q    <= w_full;
      mag1_q  <= dyr[15] ? 16'(~dyr + 16'd1) : dyr;
      neg1_q  <= dyr[15];
      prop1_q <= propagate_i;
    end
  end

  // Stage 2: |dy| * w, at most 2^45.
  logic [45:0] prod2_q;
  logic        neg2_q;
  logic        prop2_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[1]) begin
      prod2_q <= 46'(mag1_q) * 46'(w1_q);
      neg2_q  <= neg1_q;
      prop2_q <= prop1_q;
    end
  end

  // Stage 3: round the magnitude half up and drop 32 fraction bits.
  logic [45:0] rnd;
  logic [13:0] r3_q;
  logic        neg3_q;
  logic        prop3_q;

  assign rnd = prod2_q + (46'd1 << 31);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[2]) begin
      r3_q    <= rnd[45:32];
      neg3_q  <= neg2_q;
      prop3_q <= prop2_q;
    end
  end

  // Stage 4: apply the sign of dy; a word that is not propagated reads as zero.
  logic [16:0] r_ext;

  assign r_ext = 17'(r3_q);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[3]) begin
      if (!prop3_q) begin
        grad_o <= '0;
      end else if (neg3_q) begin
        grad_o <= signed'(17'(~r_ext + 17'd1));
      end else begin
        grad_o <= signed'(r_ext);
      end
      written_o <= prop3_q;
    end
  end

endmodule

[rtl/sigmoid_forward_backward_unit.sv]
// Top level of the fixed-point sigmoid unit: forward value and backward gradient.
// Depends on sfb_pkg, sfb_pipe_ctrl, sfb_fwd_path and sfb_bwd_path.
//
//   Channel  Direction  Handshake                 Word
//   input    in         in_valid_i / in_ready_o   opcode, x_in, sig_out, grad_in, propagate
//   result   out        out_valid_o / out_ready_i result_value, written
//
// One word enters per cycle and results leave one per cycle, unless out_ready_i stalls the output.
// Each word passes the four register stages (scale, table read, multiply, round) in order.
// Reset clears only the stage valid bits; the sigmoid table is a constant.
// A stalled output holds the last stage; earlier stages keep filling their bubbles.
`timescale 1ns / 1ps

module sigmoid_forward_backward_unit
  import sfb_pkg::*;
#(
  parameter int TABLE_POINTS = DefTablePoints
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               opcode_i,
  input  logic signed [15:0] x_in_i,
  input  logic [15:0]        sig_out_i,
  input  logic signed [15:0] grad_in_i,
  input  logic               propagate_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [16:0] result_value_o,
  output logic               written_o
);

  sfb_ctrl_t          ctrl;
  logic [15:0]        fwd_y;
  logic signed [16:0] bwd_grad;
  logic               bwd_written;
  logic [NumStages-1:0] op_q;

  sfb_pipe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .ctrl_o      (ctrl)
  );

  sfb_fwd_path #(
    .TABLE_POINTS (TABLE_POINTS)
  ) u_fwd (
    .clk_i  (clk_i),
    .ctrl_i (ctrl),
    .x_in_i (x_in_i),
    .y_o    (fwd_y)
  );

  sfb_bwd_path u_bwd (
    .clk_i       (clk_i),
    .ctrl_i      (ctrl),
    .sig_out_i   (sig_out_i),
    .grad_in_i   (grad_in_i),
    .propagate_i (propagate_i),
    .grad_o      (bwd_grad),
    .written_o   (bwd_written)
  );

  // The opcode rides along beside both datapaths and picks the result at the end.
  always_ff @(posedge clk_i) begin
    if (ctrl.en[0]) begin
      op_q[0] <= opcode_i;
    end
    for (int k = 1; k < NumStages; k++) begin
      if (ctrl.en[k]) begin
        op_q[k] <= op_q[k-1];
      end
    end
  end

  always_comb begin
    if (op_q[NumStages-1] == OpBackward) begin
      result_value_o = bwd_grad;
      written_o      = bwd_written;
    end else begin
      result_value_o = signed'({1'b0, fwd_y});
      written_o      = 1'b1;
    end
  end

`ifndef NO_ASSERTIONS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && op_q[NumStages-1] == OpForward |-> written_o && !result_value_o[16])
    else $error("forward word not marked written or out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && op_q[NumStages-1] == OpBackward
      |-> result_value_o >= -17'sd8192 && result_value_o <= 17'sd8192)
    else $error("gradient outside the reachable range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && op_q[NumStages-1] == OpBackward && !written_o |-> result_value_o == '0)
    else $error("unwritten gradient is not zero");
`endif

endmodule

[sim/sigmoid_forward_backward_unit_test.sv]
// Self-checking testbench for the sigmoid unit: forward values and backward gradients.
// Depends on sfb_pkg and sigmoid_forward_backward_unit from rtl/.
// Results are predicted from an independently built sigmoid table and checked in order.
`timescale 1ns / 1ps

module sigmoid_forward_backward_unit_test;
  import sfb_pkg::*;

  localparam int          TablePoints = DefTablePoints;
  localparam int          StallLimit  = 1000;
  localparam int          DrainCycles = 8;
  localparam logic [63:0] QOne        = 64'd1 << 62;

  typedef struct {
    logic        op;
    logic [15:0] x;
    logic [15:0] sig;
    logic [15:0] grad;
    logic        prop;
  } sigmoid_word_t;

  typedef struct {
    logic signed [16:0] value;
    logic               written;
  } sigmoid_result_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic               opcode;
  logic signed [15:0] x_in;
  logic [15:0]        sig_out;
  logic signed [15:0] grad_in;
  logic               propagate;
  logic               out_valid;
  logic               out_ready;
  logic signed [16:0] result_value;
  logic               written;

  logic [15:0]     sigmoid_table [0:TablePoints-1];
  sigmoid_result_t pending_results [$];
  int              mismatch_count;
  int              stall_cycles;
  bit              quiet_phase;

  sigmoid_forward_backward_unit #(
    .TABLE_POINTS(TablePoints)
  ) dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .opcode_i      (opcode),
    .x_in_i        (x_in),
    .sig_out_i     (sig_out),
    .grad_in_i     (grad_in),
    .propagate_i   (propagate),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .result_value_o(result_value),
    .written_o     (written)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Q2.62 product, kept in Q2.62.
  function automatic logic [63:0] mul_q2_62(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] prod;
    prod = {64'd0, a} * {64'd0, b};
    return prod[125:62];
  endfunction

  // Entry k is round(65535 * sigmoid(8k / (points - 1))), powers of exp(-step) in Q2.62.
  function automatic void build_sigmoid_table();
    logic [63:0] segs;
    logic [63:0] step;
    logic [63:0] e_step;
    logic [63:0] term;
    logic [63:0] pw;
    logic [63:0] den;
    logic [63:0] q;
    segs   = 64'(TablePoints - 1);
    step   = (QOne / segs) * 64'd8;
    e_step = QOne;
    term   = QOne;
    pw     = QOne;
    for (int n = 1; n <= 24; n++) begin
      term = mul_q2_62(term, step) / 64'(n);
      if (n % 2 == 1) begin
        e_step = e_step - term;
      end else begin
        e_step = e_step + term;
      end
    end
    for (int k = 0; k < TablePoints; k++) begin
      den              = (QOne + pw) >> 20;
      q                = ((64'd65535 << 43) / den + 64'd1) >> 1;
      sigmoid_table[k] = q[15:0];
      pw               = mul_q2_62(pw, e_step);
    end
  endfunction

  function automatic logic [15:0] sigmoid_of(input logic [15:0] xv);
    logic [63:0] segs;
    logic [63:0] mag;
    logic [63:0] pos;
    logic [63:0] idx;
    logic [63:0] frac;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] y;
    segs = 64'(TablePoints - 1);
    mag  = xv[15] ? (64'd65536 - {48'd0, xv}) : {48'd0, xv};
    pos  = mag * segs;
    idx  = pos >> 15;
    frac = pos & 64'h7FFF;
    if (idx >= segs) begin
      y = {48'd0, sigmoid_table[TablePoints-1]};
    end else begin
      lo = {48'd0, sigmoid_table[int'(idx)]};
      hi = {48'd0, sigmoid_table[int'(idx) + 1]};
      y  = lo + (((hi - lo) * frac + 64'h4000) >> 15);
    end
    if (xv[15]) begin
      y = 64'd65535 - y;
    end
    return y[15:0];
  endfunction

  // Gradient magnitude is rounded half up before the sign of dy goes back on.
  function automatic logic [16:0] gradient_of(input logic [15:0] yv, input logic [15:0] dy);
    logic [63:0] mag;
    logic [63:0] w;
    logic [63:0] r;
    mag = dy[15] ? (64'd65536 - {48'd0, dy}) : {48'd0, dy};
    w   = {48'd0, yv} * (64'd65536 - {48'd0, yv});
    r   = (mag * w + (64'd1 << 31)) >> 32;
    if (dy[15]) begin
      r = 64'd0 - r;
    end
    return r[16:0];
  endfunction

  function automatic sigmoid_result_t predict_result(input sigmoid_word_t w);
    sigmoid_result_t res;
    if (w.op == OpForward) begin
      res.value   = {1'b0, sigmoid_of(w.x)};
      res.written = 1'b1;
    end else if (w.prop) begin
      res.value   = gradient_of(w.sig, w.grad);
      res.written = 1'b1;
    end else begin
      res.value   = '0;
      res.written = 1'b0;
    end
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Called at a rising edge; returns at the edge where the word is taken.
  task automatic send_word(input sigmoid_word_t w);
    if (!quiet_phase && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    opcode    <= w.op;
    x_in      <= w.x;
    sig_out   <= w.sig;
    grad_in   <= w.grad;
    propagate <= w.prop;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(predict_result(w));
  endtask

  function automatic sigmoid_word_t make_word(input logic op, input logic [15:0] xv,
                                              input logic [15:0] yv, input logic [15:0] dy,
                                              input logic prop);
    sigmoid_word_t w;
    w.op   = op;
    w.x    = xv;
    w.sig  = yv;
    w.grad = dy;
    w.prop = prop;
    return w;
  endfunction

  function automatic logic [15:0] rand16();
    return 16'($urandom);
  endfunction

  task automatic test_forward_edges();
    logic [15:0] points [$];
    points = '{16'h0000, 16'h0001, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h8001, 16'h1000,
               16'hF000, 16'h00FF, 16'h0100, 16'h7F00, 16'h80FF};
    foreach (points[i]) begin
      send_word(make_word(OpForward, points[i], rand16(), rand16(), 1'($urandom)));
    end
  endtask

  task automatic test_backward_edges();
    // y = 0.5 makes the product dy/4, so dy = +-2 lands exactly on a half.
    send_word(make_word(OpBackward, rand16(), 16'h8000, 16'h0002, 1'b1));
    send_word(make_word(OpBackward, rand16(), 16'h8000, 16'hFFFE, 1'b1));
    send_word(make_word(OpBackward, rand16(), 16'h8000, 16'h7FFF, 1'b1));
    send_word(make_word(OpBackward, rand16(), 16'h8000, 16'h8000, 1'b1));
    send_word(make_word(OpBackward, rand16(), 16'h0000, 16'h7FFF, 1'b1));
    send_word(make_word(OpBackward, rand16(), 16'hFFFF, 16'h8000, 1'b1));
    send_word(make_word(OpBackward, rand16(), 16'h0001, 16'hFFFF, 1'b1));
    send_word(make_word(OpBackward, rand16(), 16'h8000, 16'h0000, 1'b1));
    send_word(make_word(OpBackward, rand16(), 16'h8000, 16'h7FFF, 1'b0));
    send_word(make_word(OpBackward, rand16(), rand16(), rand16(), 1'b0));
  endtask

  task automatic test_random_mix(input int count);
    logic [15:0] yv;
    logic [15:0] dy;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 1) == 0) begin
        send_word(make_word(OpForward, rand16(), rand16(), rand16(), 1'($urandom)));
      end else begin
        // Mostly y values that a forward pass could produce, some arbitrary or extreme.
        case ($urandom_range(0, 9))
          0:       yv = $urandom_range(0, 1) ? 16'h0000 : 16'hFFFF;
          1, 2:    yv = rand16();
          default: yv = sigmoid_of(rand16());
        endcase
        dy = ($urandom_range(0, 9) == 0) ? ($urandom_range(0, 1) ? 16'h7FFF : 16'h8000)
                                         : rand16();
        send_word(make_word(OpBackward, rand16(), yv, dy, $urandom_range(0, 6) != 0));
      end
    end
  endtask

  task automatic test_full_rate(input int count);
    quiet_phase = 1'b1;
    test_random_mix(count);
  endtask

  // Result side stalls in bursts, with runs of steady acceptance between them.
  initial begin
    out_ready <= 1'b0;
    @(posedge rst_n);
    @(posedge clk);
    forever begin
      if (!quiet_phase && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  end

  initial begin
    sigmoid_result_t exp_res;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("result word with none pending: value=%0d written=%0b",
                                    result_value, written));
        end else begin
          exp_res = pending_results.pop_front();
          if (result_value !== exp_res.value) begin
            report_mismatch($sformatf("result_value got %0d, want %0d",
                                      result_value, exp_res.value));
          end
          if (written !== exp_res.written) begin
            report_mismatch($sformatf("written got %0b, want %0b",
                                      written, exp_res.written));
          end
        end
      end
    end
  end

  // Ends the run if neither channel moves a word for too long.
  initial begin
    stall_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= StallLimit) begin
        $display("sigmoid_forward_backward_unit test failed");
        $finish;
      end
    end
  end

  initial begin
    mismatch_count = 0;
    quiet_phase    = 1'b0;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    opcode    <= OpForward;
    x_in      <= '0;
    sig_out   <= '0;
    grad_in   <= '0;
    propagate <= 1'b0;
    build_sigmoid_table();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_forward_edges();
    test_backward_edges();
    test_random_mix(1500);
    test_full_rate(330);

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("sigmoid_forward_backward_unit test passed");
    end else begin
      $display("sigmoid_forward_backward_unit test failed");
    end
    $finish;
  end

endmodule
